// File: rtl/ipv4hrc_pkg.sv
// Shared types and constants for the IPv4 receive header check.
// Holds the byte positions within the header, the verdict codes and the checksum fold.
// Depends on nothing.
package ipv4hrc_pkg;

   localparam int HEADER_BYTES = 20;
   localparam int INDEX_BITS   = 5;

   // Byte positions within the fixed 20-byte header.
   localparam logic [INDEX_BITS-1:0] IDX_VERSION_IHL = 5'd0;
   localparam logic [INDEX_BITS-1:0] IDX_TOTLEN_LO   = 5'd3;
   localparam logic [INDEX_BITS-1:0] IDX_PROTOCOL    = 5'd9;
   localparam logic [INDEX_BITS-1:0] IDX_CHECKSUM_LO = 5'd11;
   localparam logic [INDEX_BITS-1:0] IDX_DEST_FIRST  = 5'd16;
   localparam logic [INDEX_BITS-1:0] IDX_LAST        = INDEX_BITS'(HEADER_BYTES - 1);

   localparam logic [7:0] VERSION_IHL_PLAIN = 8'h45;
   localparam logic [7:0] PROTO_TCP         = 8'h06;
   localparam logic [7:0] PROTO_UDP         = 8'd17;

   typedef enum logic [2:0] {
      VERDICT_TCP        = 3'd0,
      VERDICT_UDP        = 3'd1,
      VERDICT_IGNORED    = 3'd2,
      VERDICT_BAD_SUM    = 3'd3,
      VERDICT_WRONG_DEST = 3'd4,
      VERDICT_TOO_LONG   = 3'd5,
      VERDICT_BAD_VER    = 3'd6
   } verdict_type;

   // Folds a 20-bit sum to 16 bits with end-around carry and complements it.
   function automatic logic [15:0] fold_complement(input logic [19:0] sum);
      logic [16:0] first;
      logic [16:0] second;
      first  = 17'(sum[19:16]) + 17'(sum[15:0]);
      second = 17'(first[15:0]) + 17'(first[16]);
      return ~second[15:0];
   endfunction

endpackage

// File: rtl/ipv4_header_receive_check_core.sv
// IPv4 receive header check: top level.
// Checksum, destination, length and version checks with a registered verdict.
// Depends on ipv4hrc_pkg.

// The block takes the 20 bytes of a received IPv4 header on the req_ channel,
// one byte per transfer in wire order, with req_header_start marking the first
// byte and carrying the frame length along with it. A new byte can be taken in
// every clock cycle. After the 20th byte, one result transfer on the rsp_
// channel reports the verdict (checksum, destination, total length against
// frame length, version/IHL, then TCP/UDP/other), the total length field and
// the protocol field; it appears in the cycle after the last byte is transferred.
// The result sits in an output register, so header bytes keep flowing while it
// waits; only the last byte of the following header is held off (req_ready
// low) until the previous result has been transferred. A start byte always
// restarts the header, dropping a partial one without a result, and bytes
// outside a header are swallowed. The local address is written through the
// csr_ channel, which is always ready and should only be written while no
// header is in progress and no result is pending.
module ipv4_header_receive_check_core
   import ipv4hrc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_local_address,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_header_start,
   input  logic [15:0] req_frame_length,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_verdict,
   output logic [15:0] rsp_datagram_length,
   output logic [7:0]  rsp_protocol_number
);

   // Control state.
   logic [INDEX_BITS-1:0] byte_index_ff, byte_index_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [31:0]           local_address_ff, local_address_in;

   // Header fields collected while the bytes stream past.
   logic [19:0] sum_ff, sum_in;
   logic [7:0]  high_byte_ff, high_byte_in;
   logic [15:0] checksum_ff, checksum_in;
   logic [31:0] dest_ff, dest_in;
   logic [15:0] totlen_ff, totlen_in;
   logic [7:0]  version_ff, version_in;
   logic [7:0]  protocol_ff, protocol_in;
   logic [15:0] frame_len_ff, frame_len_in;

   // Result register.
   verdict_type rsp_verdict_ff, rsp_verdict_in;
   logic [15:0] rsp_length_ff, rsp_length_in;
   logic [7:0]  rsp_protocol_ff, rsp_protocol_in;

   logic                  req_fire;
   logic                  in_header;
   logic [INDEX_BITS-1:0] cur_index;
   logic [15:0]           word;
   logic [19:0]           sum_final;
   logic [31:0]           dest_final;
   logic                  result_fire;
   verdict_type           verdict;

   // The configuration register is always ready to be written.
   assign csr_ready = 1'b1;

   // Only the last header byte produces a result, so only that byte has to
   // wait for a stalled result to drain.
   assign req_ready = !(rsp_valid_ff && !rsp_ready && byte_index_ff == IDX_LAST);
   assign req_fire  = req_valid && req_ready;

   // A start byte always begins at position zero; other bytes only count
   // while a header is open.
   assign in_header = req_header_start || (byte_index_ff != '0 && byte_index_ff <= IDX_LAST);
   assign cur_index = req_header_start ? IDX_VERSION_IHL : byte_index_ff;

   assign word        = {high_byte_ff, req_data_byte};
   assign result_fire = req_fire && in_header && cur_index == IDX_LAST;

   // The final word and the last destination byte arrive with the last byte,
   // so the verdict is formed from the stored fields plus the incoming byte.
   assign sum_final  = sum_ff + 20'(word);
   assign dest_final = {dest_ff[23:0], req_data_byte};

   always_comb begin
      if (fold_complement(sum_final) != checksum_ff) begin
         verdict = VERDICT_BAD_SUM;
      end else if (dest_final != local_address_ff) begin
         verdict = VERDICT_WRONG_DEST;
      end else if (totlen_ff > frame_len_ff) begin
         verdict = VERDICT_TOO_LONG;
      end else if (version_ff != VERSION_IHL_PLAIN) begin
         verdict = VERDICT_BAD_VER;
      end else if (protocol_ff == PROTO_TCP) begin
         verdict = VERDICT_TCP;
      end else if (protocol_ff == PROTO_UDP) begin
         verdict = VERDICT_UDP;
      end else begin
         verdict = VERDICT_IGNORED;
      end
   end

   always_comb begin
      byte_index_in    = byte_index_ff;
      local_address_in = local_address_ff;
      sum_in           = sum_ff;
      high_byte_in     = high_byte_ff;
      checksum_in      = checksum_ff;
      dest_in          = dest_ff;
      totlen_in        = totlen_ff;
      version_in       = version_ff;
      protocol_in      = protocol_ff;
      frame_len_in     = frame_len_ff;
      rsp_verdict_in   = rsp_verdict_ff;
      rsp_length_in    = rsp_length_ff;
      rsp_protocol_in  = rsp_protocol_ff;

      if (csr_valid && csr_ready) begin
         local_address_in = csr_local_address;
      end

      if (req_fire) begin
         if (!in_header) begin
            byte_index_in = '0;
         end else begin
            if (req_header_start) begin
               sum_in       = '0;
               frame_len_in = req_frame_length;
            end

            // Even positions hold the high byte of a word; odd ones complete it.
            // The checksum word is latched instead of summed.
            if (!cur_index[0]) begin
               high_byte_in = req_data_byte;
            end else if (cur_index == IDX_CHECKSUM_LO) begin
               checksum_in = word;
            end else begin
               sum_in = req_header_start ? 20'(word) : sum_final;
            end

            if (cur_index == IDX_TOTLEN_LO) begin
               totlen_in = word;
            end
            if (cur_index == IDX_VERSION_IHL) begin
               version_in = req_data_byte;
            end
            if (cur_index == IDX_PROTOCOL) begin
               protocol_in = req_data_byte;
            end
            if (cur_index >= IDX_DEST_FIRST) begin
               dest_in = dest_final;
            end

            byte_index_in = (cur_index == IDX_LAST) ? '0 : cur_index + 1'b1;
         end
      end

      if (result_fire) begin
         rsp_verdict_in  = verdict;
         rsp_length_in   = totlen_ff;
         rsp_protocol_in = protocol_ff;
      end

      if (result_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_index_ff    <= '0;
         rsp_valid_ff     <= 1'b0;
         local_address_ff <= '0;
      end else begin
         byte_index_ff    <= byte_index_in;
         rsp_valid_ff     <= rsp_valid_in;
         local_address_ff <= local_address_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff          <= sum_in;
      high_byte_ff    <= high_byte_in;
      checksum_ff     <= checksum_in;
      dest_ff         <= dest_in;
      totlen_ff       <= totlen_in;
      version_ff      <= version_in;
      protocol_ff     <= protocol_in;
      frame_len_ff    <= frame_len_in;
      rsp_verdict_ff  <= rsp_verdict_in;
      rsp_length_ff   <= rsp_length_in;
      rsp_protocol_ff <= rsp_protocol_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_verdict         = rsp_verdict_ff;
   assign rsp_datagram_length = rsp_length_ff;
   assign rsp_protocol_number = rsp_protocol_ff;

   // A result only appears after the last byte of a header was transferred.
   a_result_from_last_byte: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(req_valid && req_ready && !req_header_start
                                    && byte_index_ff == IDX_LAST))
      else $error("result appeared without a completed header");

   // The byte position never runs past the end of the header.
   a_index_in_range: assert property (@(posedge clock) disable iff (reset)
      byte_index_ff <= IDX_LAST)
      else $error("byte index beyond header");

   // A start byte always leaves the block waiting for the second byte.
   a_start_restarts: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_header_start |=> byte_index_ff == 5'd1)
      else $error("start byte did not restart the header");

   // A pending result is never overwritten by the next header's verdict.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |=> $stable(rsp_verdict_ff) && $stable(rsp_length_ff))
      else $error("pending result overwritten");

endmodule

// File: verif/tb_ipv4_header_receive_check_core.sv
// Self-checking testbench for the IPv4 receive header check core.
// Predicts every verdict from the header bytes sent and checks each result transfer.
// Depends on ipv4hrc_pkg and ipv4_header_receive_check_core from the rtl folder.
module tb_ipv4_header_receive_check_core
   import ipv4hrc_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   // A whole header as it appears on the wire, byte 0 in the top eight bits.
   typedef logic [8*HEADER_BYTES-1:0] header_image_type;

   // Top bit of each field that the generator sets inside a header image.
   localparam int VER_MSB    = 8*HEADER_BYTES - 1 - 8*IDX_VERSION_IHL;
   localparam int TOTLEN_MSB = 8*HEADER_BYTES - 1 - 8*(IDX_TOTLEN_LO - 1);
   localparam int PROTO_MSB  = 8*HEADER_BYTES - 1 - 8*IDX_PROTOCOL;
   localparam int SUM_MSB    = 8*HEADER_BYTES - 1 - 8*(IDX_CHECKSUM_LO - 1);
   localparam int DEST_MSB   = 8*HEADER_BYTES - 1 - 8*IDX_DEST_FIRST;

   // One byte waiting to be offered on the request channel.
   typedef struct packed {
      logic [7:0]  data;
      logic        start;
      logic [15:0] frame_len;
   } header_byte_type;

   // What the core is expected to report for one completed header.
   typedef struct packed {
      verdict_type verdict;
      logic [15:0] total_len;
      logic [7:0]  proto;
   } header_outcome_type;

   // Everything the core has gathered so far about the header in progress.
   typedef struct packed {
      logic [4:0]  next_slot;
      logic [19:0] sum;
      logic [7:0]  upper;
      logic [15:0] stored_sum;
      logic [31:0] dest;
      logic [15:0] total_len;
      logic [7:0]  ver_ihl;
      logic [7:0]  proto;
      logic [15:0] frame_len;
   } header_progress_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [31:0] csr_local_address = '0;

   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = '0;
   logic        req_header_start = 1'b0;
   logic [15:0] req_frame_length = '0;

   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_verdict;
   logic [15:0] rsp_datagram_length;
   logic [7:0]  rsp_protocol_number;

   // Stimulus queues, filled by the sequencing block on falling edges and
   // drained by the driver on rising edges, so the two never race.
   header_byte_type     bytes_pending[$];
   logic [31:0]         address_writes[$];
   header_outcome_type  verdicts_due[$];

   // The predictor's copy of the local address and of the header in progress.
   logic [31:0]         address_setting = '0;
   header_progress_type progress = '0;

   int unsigned send_idle_pct = 0;
   int unsigned stall_pct = 0;
   int unsigned mismatch_count = 0;

   ipv4_header_receive_check_core dut (
      .clock               (clock),
      .reset               (reset),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_local_address   (csr_local_address),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_data_byte       (req_data_byte),
      .req_header_start    (req_header_start),
      .req_frame_length    (req_frame_length),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_verdict         (rsp_verdict),
      .rsp_datagram_length (rsp_datagram_length),
      .rsp_protocol_number (rsp_protocol_number)
   );

   always #5 clock = ~clock;

   // End-around-carry fold of the running sum, then the ones' complement.
   // Folding repeats until nothing is left above bit 15.
   function automatic logic [15:0] fold_and_invert(logic [19:0] sum);
      logic [20:0] folded;
      folded = 21'(sum);
      while (folded > 21'h0ffff)
         folded = (folded & 21'h0ffff) + (folded >> 16);
      return ~folded[15:0];
   endfunction

   // Checksum that a sender would place in the header: all words but the
   // checksum word itself.
   function automatic logic [15:0] header_checksum(header_image_type h);
      logic [19:0] total;
      total = '0;
      for (int w = 0; w < HEADER_BYTES/2; w++)
         if (2*w != IDX_CHECKSUM_LO - 1)
            total += 20'(h[8*HEADER_BYTES - 1 - 16*w -: 16]);
      return fold_and_invert(total);
   endfunction

   // Advances the predicted header state by one accepted byte. After the
   // last header byte, the verdict is worked out and queued.
   function automatic void absorb_header_byte(logic [7:0] data, logic start,
                                              logic [15:0] frame_len);
      logic [4:0]         slot;
      logic [15:0]        word;
      header_outcome_type outcome;
      if (start) begin
         // A start byte always opens a fresh header, dropping any partial one.
         progress = '0;
         progress.frame_len = frame_len;
         slot = '0;
      end else if (progress.next_slot == 0 || progress.next_slot >= HEADER_BYTES) begin
         // Outside a header the byte is swallowed.
         progress.next_slot = '0;
         return;
      end else begin
         slot = progress.next_slot;
      end

      if (slot[0] == 1'b0) begin
         progress.upper = data;
      end else begin
         word = {progress.upper, data};
         if (slot == IDX_CHECKSUM_LO)
            progress.stored_sum = word;
         else
            progress.sum = progress.sum + 20'(word);
         if (slot == IDX_TOTLEN_LO)
            progress.total_len = word;
      end
      if (slot == IDX_VERSION_IHL)
         progress.ver_ihl = data;
      if (slot == IDX_PROTOCOL)
         progress.proto = data;
      if (slot >= IDX_DEST_FIRST)
         progress.dest = {progress.dest[23:0], data};

      if (slot != IDX_LAST) begin
         progress.next_slot = slot + 5'd1;
         return;
      end
      progress.next_slot = '0;

      // The checks apply in a fixed order; the first one that fails decides.
      if (fold_and_invert(progress.sum) != progress.stored_sum)
         outcome.verdict = VERDICT_BAD_SUM;
      else if (progress.dest != address_setting)
         outcome.verdict = VERDICT_WRONG_DEST;
      else if (progress.total_len > progress.frame_len)
         outcome.verdict = VERDICT_TOO_LONG;
      else if (progress.ver_ihl != VERSION_IHL_PLAIN)
         outcome.verdict = VERDICT_BAD_VER;
      else if (progress.proto == PROTO_TCP)
         outcome.verdict = VERDICT_TCP;
      else if (progress.proto == PROTO_UDP)
         outcome.verdict = VERDICT_UDP;
      else
         outcome.verdict = VERDICT_IGNORED;
      // Length and protocol are reported for every verdict, rejected or not.
      outcome.total_len = progress.total_len;
      outcome.proto = progress.proto;
      verdicts_due.push_back(outcome);
   endfunction

   // Builds a header with random filler and a correct checksum.
   function automatic header_image_type make_header(logic [7:0] ver, logic [15:0] total,
                                                    logic [7:0] proto, logic [31:0] dest);
      header_image_type h;
      h = {$urandom, $urandom, $urandom, $urandom, $urandom};
      h[VER_MSB -: 8] = ver;
      h[TOTLEN_MSB -: 16] = total;
      h[PROTO_MSB -: 8] = proto;
      h[DEST_MSB -: 32] = dest;
      h[SUM_MSB -: 16] = header_checksum(h);
      return h;
   endfunction

   // Queues the first count bytes of a header. The frame length only matters
   // on the start byte; the other bytes carry random values there.
   task automatic queue_header(header_image_type h, logic [15:0] frame, int count);
      header_byte_type b;
      for (int i = 0; i < count; i++) begin
         b.data = h[8*HEADER_BYTES - 1 - 8*i -: 8];
         b.start = (i == 0);
         b.frame_len = (i == 0) ? frame : 16'($urandom);
         bytes_pending.push_back(b);
      end
   endtask

   // Bytes with random content. Without starts they are swallowed or extend
   // a partial header; with starts they cut headers at random points.
   task automatic queue_loose_bytes(int count, bit may_start);
      header_byte_type b;
      repeat (count) begin
         b.data = 8'($urandom);
         b.start = may_start && ($urandom_range(3) == 0);
         b.frame_len = 16'($urandom);
         bytes_pending.push_back(b);
      end
   endtask

   // A complete header: half of them clean, the rest with one flaw each, or
   // with everything random.
   task automatic queue_random_header();
      header_image_type h;
      logic [7:0]       ver;
      logic [7:0]       proto;
      logic [15:0]      total;
      logic [15:0]      frame;
      logic [31:0]      dest;
      int               kind;
      kind = $urandom_range(9);
      ver = VERSION_IHL_PLAIN;
      dest = address_setting;
      total = 16'($urandom);
      frame = 16'($urandom_range(65535, total));
      case ($urandom_range(2))
         0: proto = PROTO_TCP;
         1: proto = PROTO_UDP;
         default: proto = 8'($urandom);
      endcase
      case (kind)
         6: begin
            dest = $urandom;
            if (dest == address_setting)
               dest = ~dest;
         end
         7: begin
            total = 16'($urandom_range(65535, 1));
            frame = 16'($urandom_range(total - 1, 0));
         end
         8: begin
            ver = 8'($urandom);
            if (ver == VERSION_IHL_PLAIN)
               ver = ~ver;
         end
         9: begin
            ver = 8'($urandom);
            total = 16'($urandom);
            frame = 16'($urandom);
            if ($urandom_range(1))
               dest = $urandom;
         end
         default: ;
      endcase
      h = make_header(ver, total, proto, dest);
      if (kind == 5)
         h[SUM_MSB -: 16] ^= 16'($urandom_range(65535, 1));
      else if (kind == 9 && $urandom_range(1))
         h[SUM_MSB -: 16] = 16'($urandom);
      queue_header(h, frame, HEADER_BYTES);
   endtask

   // Mostly whole headers; some cut short by the next start byte, some
   // stray bytes. Always ends on a whole header so the core is left idle.
   task automatic queue_random_traffic(int target);
      int header_bytes;
      int pick;
      int cut;
      header_bytes = 0;
      while (header_bytes < target) begin
         pick = $urandom_range(99);
         if (pick < 78) begin
            queue_random_header();
            header_bytes += HEADER_BYTES;
         end else if (pick < 88) begin
            cut = $urandom_range(HEADER_BYTES - 1, 1);
            queue_header(make_header(8'($urandom), 16'($urandom), 8'($urandom),
                                     address_setting), 16'($urandom), cut);
            header_bytes += cut;
         end else if (pick < 95) begin
            queue_loose_bytes($urandom_range(4, 1), 1'b0);
         end else begin
            queue_loose_bytes($urandom_range(6, 1), 1'b1);
         end
      end
      queue_random_header();
   endtask

   // Holds the sender back until every queued byte has been transferred and
   // every verdict has come, then lets the core settle after bytes that give
   // no result.
   task automatic settle();
      do
         @(negedge clock);
      while (bytes_pending.size() != 0 || req_valid || verdicts_due.size() != 0);
      repeat (8) @(negedge clock);
   endtask

   // Starts a phase: new idling odds and a new local address, written while
   // the core is idle.
   task automatic configure_phase(logic [31:0] address, int unsigned idle_pct,
                                  int unsigned hold_pct);
      send_idle_pct = idle_pct;
      stall_pct = hold_pct;
      address_writes.push_back(address);
      do
         @(negedge clock);
      while (address_writes.size() != 0 || csr_valid);
   endtask

   // Request and register driver. A byte is handed to the predictor on the
   // edge at which its transfer completes, and the next byte may be offered
   // on that same edge, so valid is never dropped and raised in one step.
   always @(posedge clock) begin : header_driver
      header_byte_type next_byte;
      logic            byte_taken;
      logic            write_taken;
      if (reset) begin
         req_valid <= 1'b0;
         csr_valid <= 1'b0;
      end else begin
         byte_taken = req_valid && req_ready;
         if (byte_taken)
            absorb_header_byte(req_data_byte, req_header_start, req_frame_length);
         if ((!req_valid || byte_taken) && bytes_pending.size() != 0 &&
             $urandom_range(99) >= send_idle_pct) begin
            next_byte = bytes_pending.pop_front();
            req_valid <= 1'b1;
            req_data_byte <= next_byte.data;
            req_header_start <= next_byte.start;
            req_frame_length <= next_byte.frame_len;
         end else if (byte_taken) begin
            req_valid <= 1'b0;
         end

         write_taken = csr_valid && csr_ready;
         if (write_taken)
            address_setting = csr_local_address;
         if ((!csr_valid || write_taken) && address_writes.size() != 0) begin
            csr_valid <= 1'b1;
            csr_local_address <= address_writes.pop_front();
         end else if (write_taken) begin
            csr_valid <= 1'b0;
         end
      end
   end

   // Result monitor with a randomly stalling ready. Every result transfer is
   // matched against the oldest predicted verdict, field by field.
   always @(posedge clock) begin : result_monitor
      header_outcome_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
         if (rsp_valid && rsp_ready) begin
            if (verdicts_due.size() == 0) begin
               $display("%0t: result with no header pending: verdict %0d length %0d proto %0d",
                        $time, rsp_verdict, rsp_datagram_length, rsp_protocol_number);
               mismatch_count++;
            end else begin
               want = verdicts_due.pop_front();
               if (rsp_verdict !== want.verdict) begin
                  $display("%0t: verdict expected %0d got %0d",
                           $time, want.verdict, rsp_verdict);
                  mismatch_count++;
               end
               if (rsp_datagram_length !== want.total_len) begin
                  $display("%0t: datagram length expected %0d got %0d",
                           $time, want.total_len, rsp_datagram_length);
                  mismatch_count++;
               end
               if (rsp_protocol_number !== want.proto) begin
                  $display("%0t: protocol expected %0d got %0d",
                           $time, want.proto, rsp_protocol_number);
                  mismatch_count++;
               end
            end
         end
      end
   end

   // Sequencing: reset, a directed opening, then random phases that each use
   // a different local address and a different idling pattern. Every phase
   // boundary also makes the sender wait until all verdicts are in.
   initial begin : stimulus
      header_image_type h;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // The local address is still at its reset value of zero here.
      // Stray bytes before any start byte are swallowed.
      queue_loose_bytes(2, 1'b0);
      // All summed words zero: the computed checksum is 0xffff, so a stored
      // 0xffff matches and the header falls through to the version check.
      h = '0;
      h[SUM_MSB -: 16] = 16'hffff;
      queue_header(h, 16'h0000, HEADER_BYTES);
      // Words summing to 0xffff give a computed checksum of zero; a stored
      // 0xffff is refused even though it is the same ones' complement value.
      h = '0;
      h[VER_MSB -: 8] = VERSION_IHL_PLAIN;
      h[TOTLEN_MSB -: 16] = 16'hbaff;
      queue_header(h, 16'hffff, HEADER_BYTES);
      h[SUM_MSB -: 16] = 16'hffff;
      queue_header(h, 16'hffff, HEADER_BYTES);
      // A start byte inside a header drops the partial one, late or early.
      queue_header(make_header(VERSION_IHL_PLAIN, 16'd40, PROTO_TCP, '0), 16'd60, 11);
      queue_header(make_header(VERSION_IHL_PLAIN, 16'd40, PROTO_UDP, '0), 16'd60,
                   HEADER_BYTES - 1);
      queue_header(make_header(VERSION_IHL_PLAIN, 16'd40, PROTO_TCP, '0), 16'd60,
                   HEADER_BYTES);
      settle();

      configure_phase(32'hc0a80001, 0, 0);
      // One header per verdict, several with the length fields at their extremes.
      queue_header(make_header(VERSION_IHL_PLAIN, 16'hffff, PROTO_TCP, address_setting),
                   16'hffff, HEADER_BYTES);
      queue_header(make_header(VERSION_IHL_PLAIN, 16'h0000, PROTO_UDP, address_setting),
                   16'h0000, HEADER_BYTES);
      queue_header(make_header(VERSION_IHL_PLAIN, 16'd20, 8'hff, address_setting),
                   16'd20, HEADER_BYTES);
      queue_header(make_header(VERSION_IHL_PLAIN, 16'h0001, PROTO_TCP, ~address_setting),
                   16'h0000, HEADER_BYTES);
      queue_header(make_header(VERSION_IHL_PLAIN, 16'hffff, PROTO_UDP, address_setting),
                   16'hfffe, HEADER_BYTES);
      queue_header(make_header(8'h46, 16'd40, PROTO_TCP, address_setting),
                   16'd60, HEADER_BYTES);
      // A bad checksum wins over every other fault.
      h = make_header(8'h00, 16'hffff, PROTO_TCP, ~address_setting);
      h[SUM_MSB -: 16] ^= 16'h0001;
      queue_header(h, 16'h0000, HEADER_BYTES);
      queue_random_traffic(500);
      settle();

      configure_phase(32'hffffffff, 80, 0);
      queue_random_traffic(500);
      settle();

      configure_phase(32'h00000000, 0, 80);
      queue_random_traffic(500);
      settle();

      configure_phase($urandom, 19, 19);
      queue_random_traffic(500);
      settle();

      if (mismatch_count == 0)
         $display("tb_ipv4_header_receive_check_core: PASS");
      else
         $display("tb_ipv4_header_receive_check_core: FAIL");
      $finish;
   end

   // Guards against a hung handshake; the run needs far less than this.
   initial begin : watchdog
      #2000000;
      $display("tb_ipv4_header_receive_check_core: FAIL");
      $finish;
   end

endmodule
